// ----- rtl/rmth_pkg.sv -----
// Shared constants and controller/datapath interface types for the running median block.
`default_nettype none

package rmth_pkg;

    localparam int HEAP_DEPTH_DEF  = 512;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int HELD_BITS       = 11;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the accepted transaction
        logic sel;        // heap being worked on: 0 lower (max), 1 upper (min)
        logic vsel;       // value in flight: 0 new sample, 1 saved top
        logic save_top;   // save the top of the selected heap
        logic drop;       // mark the sample as dropped
        logic push_init;  // start a push on the selected heap
        logic rt_init;    // start a replace-top on the selected heap
        logic push_rd;    // push: write at the root or read the parent
        logic push_cmp;   // push: move the parent down or place the value
        logic rt_rd;      // replace-top: place the value or read both children
        logic rt_cmp;     // replace-top: move a child up or place the value
        logic out_load;   // load the result register
    } rmth_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic l_gt;       // lower heap holds more samples
        logic l_lt;       // upper heap holds more samples
        logic x_le_ltop;  // sample <= top of lower heap
        logic ltop_le_x;  // top of lower heap <= sample
        logic utop_ge_x;  // top of upper heap >= sample
        logic l_full;
        logic u_full;
        logic idx_zero;   // sift position is the root
        logic no_child;   // sift position has no child in the heap
        logic move;       // compare says the entry moves
    } rmth_stat_t;

endpackage

`default_nettype wire

// ----- rtl/rmth_dp.sv -----
// Datapath of the running median: heap memories, counts, tops and sift logic.
`default_nettype none

module rmth_dp
    import rmth_pkg::*;
#(
    parameter int HEAP_DEPTH  = HEAP_DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire rmth_cmd_t               cmd,
    output rmth_stat_t                   stat,
    input  wire logic [SAMPLE_BITS-1:0]  in_sample,
    input  wire logic                    in_start,
    output logic [SAMPLE_BITS:0]         median_doubled,
    output logic [HELD_BITS-1:0]         samples_held,
    output logic                         dropped
);

    localparam int AW   = $clog2(HEAP_DEPTH);
    localparam int CW   = $clog2(HEAP_DEPTH + 1);
    localparam int IW   = AW + 2;
    localparam int MB   = SAMPLE_BITS + 1;
    localparam int SUMW = (CW + 1 > HELD_BITS) ? CW + 1 : HELD_BITS;

    logic signed [SAMPLE_BITS-1:0] lower_mem [HEAP_DEPTH];
    logic signed [SAMPLE_BITS-1:0] upper_mem [HEAP_DEPTH];

    logic signed [SAMPLE_BITS-1:0] rd_a_l_reg, rd_b_l_reg, rd_a_u_reg, rd_b_u_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg, save_reg, ltop_reg, utop_reg;
    logic [CW-1:0]                 lcnt_reg, ucnt_reg;
    logic [AW-1:0]                 idx_reg;
    logic                          drop_reg;
    logic [MB-1:0]                 med_reg;
    logic [HELD_BITS-1:0]          held_reg;
    logic                          drop_out_reg;

    logic signed [SAMPLE_BITS-1:0] v, rd_a, rd_b, top_sel, best_val, wdata;
    logic [CW-1:0]                 cnt_sel;
    logic [AW-1:0]                 parent, rd_addr_a, rd_addr_b, waddr, best_idx;
    logic [IW-1:0]                 child_l, child_r, cnt_ext;
    logic                          r_ok, best_r, move_rt, move_push, we;
    logic [SUMW-1:0]               held_sum;
    logic signed [MB-1:0]          med_next;

    function automatic logic ranks_above(input logic is_max,
                                         input logic signed [SAMPLE_BITS-1:0] a,
                                         input logic signed [SAMPLE_BITS-1:0] b);
        return is_max ? (a > b) : (a < b);
    endfunction

    always_comb begin
        v        = cmd.vsel ? save_reg : x_reg;
        rd_a     = cmd.sel ? rd_a_u_reg : rd_a_l_reg;
        rd_b     = cmd.sel ? rd_b_u_reg : rd_b_l_reg;
        cnt_sel  = cmd.sel ? ucnt_reg : lcnt_reg;
        top_sel  = cmd.sel ? utop_reg : ltop_reg;
        parent   = AW'((idx_reg - 1'b1) >> 1);
        child_l  = {1'b0, idx_reg, 1'b1};
        child_r  = child_l + 1'b1;
        cnt_ext  = IW'(cnt_sel);
        r_ok     = child_r < cnt_ext;
        best_r   = r_ok && ranks_above(!cmd.sel, rd_b, rd_a);
        best_val = best_r ? rd_b : rd_a;
        best_idx = best_r ? child_r[AW-1:0] : child_l[AW-1:0];
        move_rt   = ranks_above(!cmd.sel, best_val, v);
        move_push = ranks_above(!cmd.sel, v, rd_a);
        rd_addr_a = cmd.push_rd ? parent : child_l[AW-1:0];
        rd_addr_b = child_r[AW-1:0];

        stat.empty     = (lcnt_reg == '0) && (ucnt_reg == '0);
        stat.l_gt      = lcnt_reg > ucnt_reg;
        stat.l_lt      = lcnt_reg < ucnt_reg;
        stat.x_le_ltop = x_reg <= ltop_reg;
        stat.ltop_le_x = ltop_reg <= x_reg;
        stat.utop_ge_x = utop_reg >= x_reg;
        stat.l_full    = lcnt_reg == CW'(HEAP_DEPTH);
        stat.u_full    = ucnt_reg == CW'(HEAP_DEPTH);
        stat.idx_zero  = idx_reg == '0;
        stat.no_child  = child_l >= cnt_ext;
        stat.move      = cmd.rt_cmp ? move_rt : move_push;

        // One write per cycle into the selected heap.
        we    = 1'b0;
        waddr = idx_reg;
        wdata = v;
        if (cmd.push_rd && stat.idx_zero) begin
            we = 1'b1;
        end
        if (cmd.push_cmp) begin
            we    = 1'b1;
            wdata = move_push ? rd_a : v;
        end
        if (cmd.rt_rd && stat.no_child) begin
            we = 1'b1;
        end
        if (cmd.rt_cmp) begin
            we    = 1'b1;
            wdata = move_rt ? best_val : v;
        end

        held_sum = SUMW'(lcnt_reg) + SUMW'(ucnt_reg);
        if (lcnt_reg > ucnt_reg) begin
            med_next = {ltop_reg, 1'b0};
        end else if (ucnt_reg > lcnt_reg) begin
            med_next = {utop_reg, 1'b0};
        end else begin
            med_next = MB'(ltop_reg) + MB'(utop_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (we && !cmd.sel) begin
            lower_mem[waddr] <= wdata;
        end
        if (we && cmd.sel) begin
            upper_mem[waddr] <= wdata;
        end
        rd_a_l_reg <= lower_mem[rd_addr_a];
        rd_b_l_reg <= lower_mem[rd_addr_b];
        rd_a_u_reg <= upper_mem[rd_addr_a];
        rd_b_u_reg <= upper_mem[rd_addr_b];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lcnt_reg <= '0;
            ucnt_reg <= '0;
        end else begin
            if (cmd.load && in_start) begin
                lcnt_reg <= '0;
                ucnt_reg <= '0;
            end
            if (cmd.push_init && !cmd.sel) begin
                lcnt_reg <= lcnt_reg + 1'b1;
            end
            if (cmd.push_init && cmd.sel) begin
                ucnt_reg <= ucnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg    <= in_sample;
            drop_reg <= 1'b0;
        end
        if (cmd.drop) begin
            drop_reg <= 1'b1;
        end
        if (cmd.save_top) begin
            save_reg <= top_sel;
        end
        if (cmd.push_init) begin
            idx_reg <= cnt_sel[AW-1:0];
        end else if (cmd.rt_init) begin
            idx_reg <= '0;
        end else if (cmd.push_cmp && move_push) begin
            idx_reg <= parent;
        end else if (cmd.rt_cmp && move_rt) begin
            idx_reg <= best_idx;
        end
        if (we && waddr == '0 && !cmd.sel) begin
            ltop_reg <= wdata;
        end
        if (we && waddr == '0 && cmd.sel) begin
            utop_reg <= wdata;
        end
        if (cmd.out_load) begin
            med_reg      <= med_next;
            held_reg     <= held_sum[HELD_BITS-1:0];
            drop_out_reg <= drop_reg;
        end
    end

    assign median_doubled = med_reg;
    assign samples_held   = held_reg;
    assign dropped        = drop_out_reg;

endmodule

`default_nettype wire

// ----- rtl/rmth_ctrl.sv -----
// Controller state machine that sequences each insert of the running median.
`default_nettype none

module rmth_ctrl
    import rmth_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    input  wire rmth_stat_t stat,
    output rmth_cmd_t       cmd
);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_DECIDE   = 8'b0000_0010,
        ST_PUSH_RD  = 8'b0000_0100,
        ST_PUSH_CMP = 8'b0000_1000,
        ST_RT_RD    = 8'b0001_0000,
        ST_RT_CMP   = 8'b0010_0000,
        ST_SECOND   = 8'b0100_0000,
        ST_FINISH   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   sel_reg, sel_next, vsel_reg, vsel_next, m_valid_reg, m_valid_next;
    logic   dec_sel, dec_rt, dec_drop, out_free;

    always_comb begin
        // Choose the heap operation from the counts and tops.
        dec_sel  = 1'b0;
        dec_rt   = 1'b0;
        dec_drop = 1'b0;
        if (stat.empty) begin
            dec_sel = 1'b0;
        end else if (stat.l_gt) begin
            dec_sel = !stat.ltop_le_x ? 1'b0 : 1'b1;
            dec_rt  = !stat.ltop_le_x;
        end else if (stat.l_lt) begin
            dec_sel = stat.utop_ge_x ? 1'b0 : 1'b1;
            dec_rt  = !stat.utop_ge_x;
        end else if (stat.x_le_ltop) begin
            dec_sel  = 1'b0;
            dec_drop = stat.l_full;
        end else begin
            dec_sel  = 1'b1;
            dec_drop = stat.u_full;
        end
    end

    always_comb begin
        state_next   = state_reg;
        sel_next     = sel_reg;
        vsel_next    = vsel_reg;
        m_valid_next = m_valid_reg;
        out_free     = !m_valid_reg || m_tready;
        s_tready     = state_reg == ST_IDLE;
        cmd          = '0;
        cmd.sel      = sel_reg;
        cmd.vsel     = vsel_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                cmd.load = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                cmd.sel   = dec_sel;
                cmd.vsel  = 1'b0;
                sel_next  = dec_sel;
                vsel_next = 1'b0;
                if (dec_drop) begin
                    cmd.drop   = 1'b1;
                    state_next = ST_FINISH;
                end else if (dec_rt) begin
                    cmd.save_top = 1'b1;
                    cmd.rt_init  = 1'b1;
                    state_next   = ST_RT_RD;
                end else begin
                    cmd.push_init = 1'b1;
                    state_next    = ST_PUSH_RD;
                end
            end
            ST_RT_RD: begin
                cmd.rt_rd  = 1'b1;
                state_next = stat.no_child ? ST_SECOND : ST_RT_CMP;
            end
            ST_RT_CMP: begin
                cmd.rt_cmp = 1'b1;
                state_next = stat.move ? ST_RT_RD : ST_SECOND;
            end
            ST_SECOND: begin
                cmd.sel       = !sel_reg;
                cmd.vsel      = 1'b1;
                cmd.push_init = 1'b1;
                sel_next      = !sel_reg;
                vsel_next     = 1'b1;
                state_next    = ST_PUSH_RD;
            end
            ST_PUSH_RD: begin
                cmd.push_rd = 1'b1;
                state_next  = stat.idx_zero ? ST_FINISH : ST_PUSH_CMP;
            end
            ST_PUSH_CMP: begin
                cmd.push_cmp = 1'b1;
                state_next   = stat.move ? ST_PUSH_RD : ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sel_reg     <= 1'b0;
            vsel_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sel_reg     <= sel_next;
            vsel_reg    <= vsel_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

`default_nettype wire

// ----- rtl/running_median_two_heaps.sv -----
// Top level of the running median block built on a max-heap and a min-heap.
`default_nettype none

// Channel  | Direction | Payload
// ---------+-----------+-------------------------------------------------------
// s_       | in        | tdata: sample (signed); tuser: start_new
// m_       | out       | tdata: median_doubled (signed), samples_held; tuser: dropped
//
// Each transaction runs alone through the controller: it is accepted, then
// decided; unless the sample is dropped, a replace-top sift (if needed) and a
// push sift follow, each with a read state and a compare state per level, and
// the result is loaded last. Each heap has its own memory with registered reads.
// Reset (aresetn low at a clock edge) empties both heaps; heap memories are
// not cleared. A stalled result is held in the output register; the next
// transaction is accepted meanwhile and waits to finish until it is taken.

module running_median_two_heaps
    import rmth_pkg::*;
#(
    parameter int HEAP_DEPTH  = HEAP_DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // tdata: sample [SAMPLE_BITS-1:0], zero padded to whole bytes
    input  wire logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // tuser: start_new
    input  wire logic                s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // tdata: median_doubled [SAMPLE_BITS:0], then samples_held, zero padded
    output logic [((SAMPLE_BITS + 1 + HELD_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // tuser: dropped
    output logic                     m_tuser
);

    localparam int MB = SAMPLE_BITS + 1;

    rmth_cmd_t            cmd;
    rmth_stat_t           stat;
    logic [MB-1:0]        median_doubled;
    logic [HELD_BITS-1:0] samples_held;

    // The controller owns the handshakes and sequencing of the sifts.
    rmth_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the heaps, their counts and cached tops.
    rmth_dp #(
        .HEAP_DEPTH  (HEAP_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .in_sample      (s_tdata[SAMPLE_BITS-1:0]),
        .in_start       (s_tuser),
        .median_doubled (median_doubled),
        .samples_held   (samples_held),
        .dropped        (m_tuser)
    );

    // Pack the result fields from the lowest bit up; padding stays zero.
    always_comb begin
        m_tdata                   = '0;
        m_tdata[MB-1:0]           = median_doubled;
        m_tdata[MB +: HELD_BITS]  = samples_held;
    end

endmodule

`default_nettype wire

// ----- verif/tb_running_median_two_heaps.sv -----
// Self-checking testbench for the running median block: directed table, then random traffic.
`default_nettype none

module tb_running_median_two_heaps;
    timeunit 1ns;
    timeprecision 1ps;
    import rmth_pkg::*;

    localparam int DEPTH    = HEAP_DEPTH_DEF;
    localparam int SBITS    = SAMPLE_BITS_DEF;
    localparam int SD_W     = ((SBITS + 7) / 8) * 8;
    localparam int MD_W     = ((SBITS + 1 + HELD_BITS + 7) / 8) * 8;
    localparam int N_RANDOM = 680;
    // Watchdog limit, above the block's worst case plus a stall on each side.
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic signed [SBITS:0] median2;
        logic [HELD_BITS-1:0]  held;
        logic                  dropped;
    } median_result_t;

    // One row of the directed table. When has_exp is set, the typed-in result
    // must also agree with the predictor.
    typedef struct {
        logic signed [SBITS-1:0] sample;
        logic                    restart;
        logic                    has_exp;
        median_result_t          exp_res;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [SD_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [MD_W-1:0] m_tdata;
    logic m_tuser;

    running_median_two_heaps dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    // Predictor state: the two halves of the running set.
    logic signed [SBITS-1:0] low_half [DEPTH];   // max-heap
    logic signed [SBITS-1:0] high_half [DEPTH];  // min-heap
    int low_n;
    int high_n;

    median_result_t pending_medians[$];
    int  errors = 0;
    bit  quiet_tail = 0;   // no idling on either side in the final stretch

    function automatic bit outranks(bit is_max, logic signed [SBITS-1:0] a,
                                    logic signed [SBITS-1:0] b);
        return is_max ? (a > b) : (a < b);
    endfunction

    task automatic heap_insert(bit is_max, logic signed [SBITS-1:0] v);
        int i;
        int parent;
        i = is_max ? low_n : high_n;
        if (is_max) low_n++; else high_n++;
        while (i > 0) begin
            parent = (i - 1) / 2;
            if (!outranks(is_max, v, is_max ? low_half[parent] : high_half[parent])) break;
            if (is_max) low_half[i] = low_half[parent];
            else high_half[i] = high_half[parent];
            i = parent;
        end
        if (is_max) low_half[i] = v; else high_half[i] = v;
    endtask

    task automatic heap_swap_top(bit is_max, logic signed [SBITS-1:0] v);
        int i;
        int l;
        int best;
        int n;
        logic signed [SBITS-1:0] cb;
        i = 0;
        n = is_max ? low_n : high_n;
        forever begin
            l = 2 * i + 1;
            if (l >= n) break;
            best = l;
            if (l + 1 < n && outranks(is_max, is_max ? low_half[l+1] : high_half[l+1],
                                      is_max ? low_half[l] : high_half[l]))
                best = l + 1;
            cb = is_max ? low_half[best] : high_half[best];
            if (!outranks(is_max, cb, v)) break;
            if (is_max) low_half[i] = cb; else high_half[i] = cb;
            i = best;
        end
        if (is_max) low_half[i] = v; else high_half[i] = v;
    endtask

    function automatic median_result_t current_median(bit dropped);
        median_result_t r;
        if (low_n > high_n) r.median2 = (SBITS+1)'(2 * low_half[0]);
        else if (high_n > low_n) r.median2 = (SBITS+1)'(2 * high_half[0]);
        else r.median2 = (SBITS+1)'(low_half[0]) + (SBITS+1)'(high_half[0]);
        r.held = HELD_BITS'(low_n + high_n);
        r.dropped = dropped;
        return r;
    endfunction

    task automatic predict_median(logic signed [SBITS-1:0] x, logic restart,
                                  output median_result_t r);
        logic signed [SBITS-1:0] top;
        bit dropped;
        dropped = 0;
        if (restart) begin
            low_n = 0;
            high_n = 0;
        end
        if (low_n == 0 && high_n == 0) begin
            heap_insert(1, x);
        end else if (low_n > high_n) begin
            top = low_half[0];
            if (top <= x) heap_insert(0, x);
            else begin
                heap_swap_top(1, x);
                heap_insert(0, top);
            end
        end else if (low_n < high_n) begin
            top = high_half[0];
            if (top >= x) heap_insert(1, x);
            else begin
                heap_swap_top(0, x);
                heap_insert(1, top);
            end
        end else if (x <= low_half[0]) begin
            if (low_n >= DEPTH) dropped = 1; else heap_insert(1, x);
        end else begin
            if (high_n >= DEPTH) dropped = 1; else heap_insert(0, x);
        end
        r = current_median(dropped);
    endtask

    // Offer one transaction, with a random idle burst before it now and then,
    // and record the expected median once it is accepted. tvalid stays high
    // after the handshake and is dropped only when the sender idles.
    task automatic send_sample(logic signed [SBITS-1:0] x, logic restart,
                               bit has_exp, median_result_t typed);
        median_result_t r;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= SD_W'(unsigned'(x));
        s_tuser <= restart;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_median(x, restart, r);
        if (has_exp && r !== typed) begin
            $display("%0t: table row disagrees: expected %0d/%0d/%0d predicted %0d/%0d/%0d",
                     $time, typed.median2, typed.held, typed.dropped,
                     r.median2, r.held, r.dropped);
            errors++;
        end
        pending_medians = {pending_medians, r};
    endtask

    // Result side: random stall bursts, then check each accepted transaction.
    int stall_left = 0;
    always @(posedge aclk) begin
        median_result_t got;
        median_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.median2 = m_tdata[SBITS:0];
                got.held = m_tdata[SBITS+1 +: HELD_BITS];
                got.dropped = m_tuser;
                if (pending_medians.size() == 0) begin
                    $display("%0t: unexpected result %0d/%0d/%0d", $time,
                             got.median2, got.held, got.dropped);
                    errors++;
                end else begin
                    want = pending_medians.pop_front();
                    if (got.median2 !== want.median2) begin
                        $display("%0t: median_doubled expected %0d actual %0d",
                                 $time, want.median2, got.median2);
                        errors++;
                    end
                    if (got.held !== want.held) begin
                        $display("%0t: samples_held expected %0d actual %0d",
                                 $time, want.held, got.held);
                        errors++;
                    end
                    if (got.dropped !== want.dropped) begin
                        $display("%0t: dropped expected %0b actual %0b",
                                 $time, want.dropped, got.dropped);
                        errors++;
                    end
                end
            end
            if (quiet_tail) m_tready <= 1'b1;
            else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                stall_left <= $urandom_range(0, 7);
                m_tready <= 1'b0;
            end else m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles without any accepted transaction.
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else if (aresetn) idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_running_median_two_heaps: FAIL");
            $finish;
        end
    end

    function automatic median_result_t mk(int m2, int held, bit drp);
        median_result_t r;
        r.median2 = (SBITS+1)'(m2);
        r.held = HELD_BITS'(held);
        r.dropped = drp;
        return r;
    endfunction

    initial begin
        stim_row_t rows[$];
        median_result_t none;
        logic signed [SBITS-1:0] x;
        int n;
        int k;
        none = '0;
        low_n = 0;
        high_n = 0;

        // Extremes, both doubling limits, ties, restarts and both rebalancing swaps.
        rows = '{
            '{16'sh8000, 1'b0, 1'b1, mk(-65536, 1, 0)},  // empty after reset
            '{16'sh8000, 1'b0, 1'b1, mk(-65536, 2, 0)},  // tie with lower top
            '{16'sh7fff, 1'b0, 1'b1, mk(-65536, 3, 0)},
            '{16'sh7fff, 1'b0, 1'b1, mk(-1, 4, 0)},
            '{16'sh7fff, 1'b0, 1'b1, mk(65534, 5, 0)},
            '{16'sh7fff, 1'b1, 1'b1, mk(65534, 1, 0)},   // restart
            '{16'sh8000, 1'b0, 1'b1, mk(-1, 2, 0)},      // swap into upper
            '{16'sh0000, 1'b0, 1'b0, none},
            '{-16'sd5,   1'b0, 1'b0, none},
            '{16'sd5,    1'b0, 1'b0, none},
            '{16'sh5555, 1'b0, 1'b0, none},
            '{-16'sh5556,1'b0, 1'b0, none},
            '{16'sd0,    1'b1, 1'b1, mk(0, 1, 0)},
            '{16'sd10,   1'b0, 1'b1, mk(10, 2, 0)},
            '{16'sd3,    1'b0, 1'b1, mk(6, 3, 0)},      // upper becomes the larger half
            '{16'sd3,    1'b0, 1'b0, none},
            '{-16'sd1,   1'b1, 1'b1, mk(-2, 1, 0)},
            '{16'sd1,    1'b1, 1'b1, mk(2, 1, 0)}
        };

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) send_sample(rows[i].sample, rows[i].restart,
                                      rows[i].has_exp, rows[i].exp_res);

        // Pause until the block has drained.
        s_tvalid <= 1'b0;
        while (pending_medians.size() != 0) @(posedge aclk);

        // Random runs, mostly short, with narrow or full-range values.
        n = 0;
        while (n < N_RANDOM) begin
            int run_len;
            bit narrow;
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 30);
            narrow = $urandom_range(0, 1);
            for (k = 0; k < run_len && n < N_RANDOM; k++) begin
                if (n > N_RANDOM - 60) quiet_tail = 1;
                x = narrow ? SBITS'($signed($urandom_range(0, 8)) - 4) : SBITS'($urandom());
                send_sample(x, k == 0, 1'b0, none);
                n++;
            end
        end

        s_tvalid <= 1'b0;
        while (pending_medians.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (errors == 0) $display("tb_running_median_two_heaps: PASS");
        else $display("tb_running_median_two_heaps: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
